>>> rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and the lead-byte classifier of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_2BYTE  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3BYTE  = 21'h000800;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_4BYTE  = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;

  // sequence length codes (continuation bytes of the open sequence)
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

  // outcome of a byte seen with no sequence open
  typedef struct packed {
    logic            emit;   // gives a result at once
    logic [CP_W-1:0] cp;
    logic            rep;
    logic [1:0]      need;   // continuation bytes to expect
    logic [CP_W-1:0] part;   // payload bits of the lead byte
  } start_t;

  // one queue entry: the one or two results caused by an input byte
  typedef struct packed {
    logic            two;    // second result present
    logic [CP_W-1:0] cp0;
    logic            rep0;
    logic [CP_W-1:0] cp1;
    logic            rep1;
    logic            last;   // byte ended the string
  } entry_t;

  function automatic start_t start_decode(input logic [7:0] b);
    start_t s;
    s = '{emit: 1'b0, cp: '0, rep: 1'b0, need: SEQ_NONE, part: '0};
    unique casez (b)
      8'b0???????: begin
        s.emit = 1'b1;
        s.cp   = {13'd0, b};
      end
      8'b10??????: begin
        s.emit = 1'b1;
        s.cp   = REPL_CP;
        s.rep  = 1'b1;
      end
      8'b110?????: begin
        s.need = SEQ_TWO;
        s.part = {16'd0, b[4:0]};
      end
      8'b1110????: begin
        s.need = SEQ_THREE;
        s.part = {17'd0, b[3:0]};
      end
      8'b11110???: begin
        s.need = SEQ_FOUR;
        s.part = {18'd0, b[2:0]};
      end
      default: begin
        s.emit = 1'b1;
        s.cp   = REPL_CP;
        s.rep  = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

>>> rtl/utf8_to_code_point_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// UTF-8 byte stream to code points, with U+FFFD for malformed input.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one UTF-8 byte per beat on s_tdata, s_tlast marks the last
//   byte of a string. Master side: one code point per beat on m_tdata;
//   m_tuser[0] flags a replacement for bad input, m_tuser[1] marks the last
//   result caused by an input byte, m_tlast marks the last character of the
//   string.
//   A byte may give no result (lead or inner continuation byte), one, or two
//   (a cut-off sequence followed by a byte that itself gives a result, or an
//   open sequence at the end of the string).
//   A result is registered in the FIFO before it reaches the master side.
//   The slave side takes one byte per cycle while the FIFO is not full; the
//   output side needs one beat per result, so a byte with two results holds
//   the back end until its second result is taken. The front decodes
//   combinationally into a QUEUE_DEPTH-entry FIFO; s_tready drops only when
//   that FIFO is full, so a stalled receiver backs up the FIFO first and then
//   the sender. Reset clears the open sequence and empties the FIFO; no clearing pass.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder
  import utf8d_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] replaced, [1] last_of_item
  output logic        m_tlast    // final_char
);

  logic   push;
  entry_t push_entry;
  logic   q_valid, q_ready;
  entry_t q_entry;

  // front: sequence state and classification, one byte per beat
  utf8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_tvalid && s_tready),
    .byte_in   (s_tdata),
    .last_byte (s_tlast),
    .push      (push),
    .entry     (push_entry)
  );

  // decouples the sender from a stalling receiver
  utf8d_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (s_tready),
    .wr_data  (push_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_entry)
  );

  // back: one output beat per result
  utf8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_entry),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Takes one byte per beat, tracks the open sequence, and builds the queue
// entry holding the results the byte causes.
// ----------------------------------------------------------------------------
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  output logic       push,
  output entry_t     entry
);

  logic [1:0]      need, need_next;
  logic [1:0]      seq_len, seq_len_next;
  logic [CP_W-1:0] part, part_next;

  start_t          sb;
  logic [1:0]      n;
  logic            ok;
  logic [CP_W-1:0] x;

  always_comb begin
    sb           = start_decode(byte_in);
    need_next    = need;
    seq_len_next = seq_len;
    part_next    = part;
    n            = 2'd0;
    ok           = 1'b0;
    x            = {part[CP_W-7:0], byte_in[5:0]};
    entry        = '{two: 1'b0, cp0: '0, rep0: 1'b0, cp1: '0, rep1: 1'b0,
                     last: last_byte};

    if ((need != SEQ_NONE) && (byte_in[7:6] == 2'b10)) begin
      part_next = x;
      need_next = need - 2'd1;
      if (need_next == SEQ_NONE) begin
        unique case (seq_len)
          SEQ_TWO:   ok = (x >= MIN_2BYTE);
          SEQ_THREE: ok = (x >= MIN_3BYTE) && ((x < SURR_LO) || (x > SURR_HI));
          default:   ok = (x >= MIN_4BYTE) && (x <= MAX_CP);
        endcase
        entry.cp0    = ok ? x : REPL_CP;
        entry.rep0   = !ok;
        n            = 2'd1;
        seq_len_next = SEQ_NONE;
        part_next    = '0;
      end
    end else begin
      // cut-off sequence: replace it, then the byte starts anew
      if (need != SEQ_NONE) begin
        entry.cp0  = REPL_CP;
        entry.rep0 = 1'b1;
        n          = 2'd1;
      end
      need_next    = sb.need;
      seq_len_next = sb.need;
      part_next    = sb.part;
      if (sb.emit) begin
        if (n == 2'd0) begin
          entry.cp0  = sb.cp;
          entry.rep0 = sb.rep;
        end else begin
          entry.cp1  = sb.cp;
          entry.rep1 = sb.rep;
        end
        n = n + 2'd1;
      end
    end

    if (last_byte) begin
      // sequence still open at end of string
      if (need_next != SEQ_NONE) begin
        if (n == 2'd0) begin
          entry.cp0  = REPL_CP;
          entry.rep0 = 1'b1;
        end else begin
          entry.cp1  = REPL_CP;
          entry.rep1 = 1'b1;
        end
        n = n + 2'd1;
      end
      need_next    = SEQ_NONE;
      seq_len_next = SEQ_NONE;
      part_next    = '0;
    end

    entry.two = (n == 2'd2);
    push      = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need    <= SEQ_NONE;
      seq_len <= SEQ_NONE;
      part    <= '0;
    end else if (accept) begin
      need    <= need_next;
      seq_len <= seq_len_next;
      part    <= part_next;
    end
  end

endmodule

>>> rtl/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Short register FIFO of decoded entries between front and back.
// ----------------------------------------------------------------------------
module utf8d_queue
  import utf8d_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  entry_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output entry_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt != CNT_W'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("queue count did not advance on push");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (cnt == '0) && !rd_valid)
    else $error("queue not empty after reset");

endmodule

>>> rtl/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Unpacks queue entries into output beats, one or two per entry.
// ----------------------------------------------------------------------------
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_valid,
  output logic        rd_ready,
  input  entry_t      rd_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] replaced, [1] last_of_item
  output logic        m_tlast    // final_char
);

  logic            second;   // second result of a two-result entry
  logic            is_last;
  logic [CP_W-1:0] cp;
  logic            rep;

  assign is_last  = !rd_data.two || second;
  assign cp       = second ? rd_data.cp1  : rd_data.cp0;
  assign rep      = second ? rd_data.rep1 : rd_data.rep0;
  assign m_tvalid = rd_valid;
  assign m_tdata  = {3'd0, cp};
  assign m_tuser  = {is_last, rep};
  assign m_tlast  = is_last && rd_data.last;
  assign rd_ready = m_tready && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      second <= !is_last;
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: UTF-8 decoder testbench
// Streams UTF-8 strings into utf8_to_code_point_decoder, predicts each code
// point beat in the bench and compares every master-side beat in order.
// Directed strings hit the field extremes and each malformed case; random
// strings then mix well-formed characters, truncated sequences and noise.
// Both sides idle at random, except in the full-rate test.
// ----------------------------------------------------------------------------
module tb_top
  import utf8d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no beat on either side
  localparam int unsigned TAIL_CYCLES = 16;    // settle time after the last beat
  localparam int unsigned MAX_REPORTS = 10;

  // one predicted master-side beat
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            rep;   // replacement for bad input
    logic            fin;   // last character of the string
    logic            lst;   // last result of its input byte
  } cp_beat_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;    // [7:0] byte_in
  logic        s_tlast  = 1'b0;  // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [20:0] code_point, [23:21] zero
  logic [1:0]  m_tuser;          // [0] replaced, [1] last_of_item
  logic        m_tlast;          // final_char

  // bench-side decoder state
  logic [1:0]      seq_need = '0;  // continuation bytes still owed
  logic [1:0]      seq_len  = SEQ_NONE;
  logic [CP_W-1:0] seq_bits = '0;

  cp_beat_t    code_points_due[$];  // predicted beats, oldest first
  logic [7:0]  byte_buf[$];         // string being sent
  logic        no_idle      = 1'b0; // both sides run at full rate
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  utf8_to_code_point_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic cp_beat_t mk_beat(input logic [CP_W-1:0] c, input logic r);
    mk_beat = '{cp: c, rep: r, fin: 1'b0, lst: 1'b0};
  endfunction

  function automatic void drop_sequence();
    seq_need = '0;
    seq_len  = SEQ_NONE;
    seq_bits = '0;
  endfunction

  // Byte seen with no sequence open. Returns 1 when it gives a beat at once;
  // otherwise a lead byte has opened a sequence.
  function automatic logic take_lead(input logic [7:0] b, output cp_beat_t r);
    r = mk_beat(REPL_CP, 1'b1);  // stray continuation and 11111xxx leads
    take_lead = 1'b1;
    if (b[7:5] == 3'b110) begin
      seq_need = 2'd1;
      seq_len  = SEQ_TWO;
      seq_bits = {16'd0, b[4:0]};
      take_lead = 1'b0;
    end else if (b[7:4] == 4'b1110) begin
      seq_need = 2'd2;
      seq_len  = SEQ_THREE;
      seq_bits = {17'd0, b[3:0]};
      take_lead = 1'b0;
    end else if (b[7:3] == 5'b11110) begin
      seq_need = 2'd3;
      seq_len  = SEQ_FOUR;
      seq_bits = {18'd0, b[2:0]};
      take_lead = 1'b0;
    end else if (!b[7]) begin
      r = mk_beat({13'd0, b}, 1'b0);
    end
  endfunction

  // Advance the bench decoder by one accepted byte and queue its beats.
  function automatic void predict_byte(input logic [7:0] b, input logic l);
    cp_beat_t        res [2];
    cp_beat_t        r;
    int              n;
    logic            ok;
    n = 0;
    if (seq_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
        seq_need = seq_need - 2'd1;
        if (seq_need == 2'd0) begin
          // reject overlong forms, surrogates and values past the top
          case (seq_len)
            SEQ_TWO:   ok = seq_bits >= MIN_2BYTE;
            SEQ_THREE: ok = seq_bits >= MIN_3BYTE &&
                            (seq_bits < SURR_LO || seq_bits > SURR_HI);
            default:   ok = seq_bits >= MIN_4BYTE && seq_bits <= MAX_CP;
          endcase
          res[n] = ok ? mk_beat(seq_bits, 1'b0) : mk_beat(REPL_CP, 1'b1);
          n++;
          drop_sequence();
        end
      end else begin
        // cut-off sequence: replace it, then decode this byte afresh
        res[n] = mk_beat(REPL_CP, 1'b1);
        n++;
        drop_sequence();
        if (take_lead(b, r)) begin
          res[n] = r;
          n++;
        end
      end
    end else if (take_lead(b, r)) begin
      res[n] = r;
      n++;
    end
    if (l) begin
      // sequence still open at end of string
      if (seq_need != 2'd0) begin
        res[n] = mk_beat(REPL_CP, 1'b1);
        n++;
      end
      drop_sequence();
      res[n-1].fin = 1'b1;
    end
    if (n > 0) res[n-1].lst = 1'b1;
    for (int i = 0; i < n; i++) code_points_due.push_back(res[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Slave side driver
  // --------------------------------------------------------------------------
  // Holds tvalid across back-to-back beats; only drops it for an idle gap.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!no_idle && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    predict_byte(b, l);
  endtask

  task automatic send_buffer();
    foreach (byte_buf[i]) send_byte(byte_buf[i], i == byte_buf.size() - 1);
  endtask

  // Stop sending until every predicted beat has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (code_points_due.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Random string builder
  // --------------------------------------------------------------------------
  function automatic void push_utf8(input logic [CP_W-1:0] c, input int len);
    case (len)
      1: byte_buf.push_back({1'b0, c[6:0]});
      2: begin
        byte_buf.push_back({3'b110, c[10:6]});
        byte_buf.push_back({2'b10, c[5:0]});
      end
      3: begin
        byte_buf.push_back({4'b1110, c[15:12]});
        byte_buf.push_back({2'b10, c[11:6]});
        byte_buf.push_back({2'b10, c[5:0]});
      end
      default: begin
        byte_buf.push_back({5'b11110, c[20:18]});
        byte_buf.push_back({2'b10, c[17:12]});
        byte_buf.push_back({2'b10, c[11:6]});
        byte_buf.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  // Mostly well-formed characters, plus raw payloads (overlong, surrogate,
  // out of range), truncated sequences and arbitrary bytes.
  function automatic void fill_string();
    int              n_chars;
    int              pick;
    int              len;
    logic [CP_W-1:0] c;
    byte_buf.delete();
    n_chars = $urandom_range(24, 1);
    for (int k = 0; k < n_chars; k++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        push_utf8(CP_W'($urandom_range(8'h7F, 0)), 1);
      end else if (pick < 45) begin
        push_utf8(CP_W'($urandom_range(12'h7FF, 8'h80)), 2);
      end else if (pick < 62) begin
        // lean toward the surrogate window now and then
        c = ($urandom_range(4) == 0) ? CP_W'($urandom_range(16'hE0FF, 16'hD700))
                                     : CP_W'($urandom_range(16'hFFFF, 12'h800));
        push_utf8(c, 3);
      end else if (pick < 75) begin
        push_utf8(CP_W'($urandom_range(21'h10FFFF, 21'h10000)), 4);
      end else if (pick < 82) begin
        push_utf8(CP_W'($urandom), $urandom_range(4, 2));
      end else if (pick < 90) begin
        len = $urandom_range(4, 2);
        push_utf8(CP_W'($urandom), len);
        repeat ($urandom_range(len - 1, 1)) void'(byte_buf.pop_back());
      end else begin
        byte_buf.push_back(8'($urandom_range(255, 0)));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // min two-byte, a well-formed U+FFFD (not flagged), max code point
  task automatic test_well_formed();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBD, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  // stray continuation, 11111xxx lead, overlong, surrogate, past U+10FFFF
  task automatic test_malformed();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // cut off by ASCII (two beats from one byte); cut off by a lead that is
  // itself left open at the end of the string
  task automatic test_cut_off();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_random_strings(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      fill_string();
      send_buffer();
      sent += byte_buf.size();
    end
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    test_random_strings(300);
    no_idle = 1'b0;
  endtask

  // sender holds off until the decoder has fully emptied, then resumes
  task automatic test_pause_and_resume();
    repeat (8) begin
      fill_string();
      send_buffer();
      wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Master side: random backpressure and result checking
  // --------------------------------------------------------------------------
  always @(posedge clk) m_tready <= no_idle || ($urandom_range(99) >= 30);

  always @(posedge clk) begin : check_beat
    cp_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (code_points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat cp=%h rep=%b lst=%b fin=%b",
                   $time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
      end else begin
        want = code_points_due.pop_front();
        if (m_tdata !== {3'b000, want.cp} || m_tuser[0] !== want.rep ||
            m_tuser[1] !== want.lst || m_tlast !== want.fin) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: expected cp=%h rep=%b lst=%b fin=%b, got cp=%h rep=%b lst=%b fin=%b",
                     $time, want.cp, want.rep, want.lst, want.fin,
                     m_tdata, m_tuser[0], m_tuser[1], m_tlast);
        end
      end
    end
  end

  // hang guard: any beat on either side resets the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ascii();
    test_well_formed();
    test_malformed();
    test_cut_off();
    test_random_strings(800);
    test_full_rate();
    test_pause_and_resume();
    wait_drained();
    // extra cycles so a stray trailing beat is caught
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && code_points_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
